@@ rtl/ssi_pkg.sv @@
// ============================================================================
// ssi_pkg: shared types and defaults for the segment intersection pipeline
// Holds the default coordinate width and the control word that travels
// beside the data from stage to stage.
// ============================================================================
package ssi_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Control word that rides along with every pipeline stage.
    typedef struct packed {
        logic valid;  // stage holds a live word
        logic hit;    // both segment parameters lie in [0,1]
        logic neg_x;  // direction of A along x is negative
        logic neg_y;  // direction of A along y is negative
    } ssi_ctl_t;

endpackage

@@ rtl/ssi_front.sv @@
// ============================================================================
// ssi_front: geometry front end
// Four stages: edge differences, cross products, denominator and numerators,
// then the hit decision and the magnitudes that feed the crossing point.
// ============================================================================
module ssi_front #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
    output ssi_pkg::ssi_ctl_t             ctl,
    output logic signed [COORD_WIDTH-1:0] start_x,
    output logic signed [COORD_WIDTH-1:0] start_y,
    output logic [COORD_WIDTH-1:0]        dx_mag,
    output logic [COORD_WIDTH-1:0]        dy_mag,
    output logic [2*COORD_WIDTH:0]        den_mag,
    output logic [2*COORD_WIDTH:0]        na_mag
);
    import ssi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;       // coordinate difference
    localparam int PW = 2 * W + 1;   // cross product
    localparam int NW = 2 * W + 2;   // denominator and numerators
    localparam int MW = 2 * W + 1;   // magnitude of denominator or numerator

    // stage 1: differences
    logic                 v1_reg;
    logic signed [W-1:0]  ax0_1_reg, ay0_1_reg;
    logic signed [DW-1:0] dxa_1_reg, dya_1_reg, dxb_1_reg, dyb_1_reg, ox_1_reg, oy_1_reg;
    logic signed [DW-1:0] dxa_1_next, dya_1_next, dxb_1_next, dyb_1_next;
    logic signed [DW-1:0] ox_1_next, oy_1_next;

    // stage 2: products
    logic                 v2_reg;
    logic signed [W-1:0]  ax0_2_reg, ay0_2_reg;
    logic signed [DW-1:0] dxa_2_reg, dya_2_reg;
    logic signed [PW-1:0] p_den0_reg, p_den1_reg, p_na0_reg, p_na1_reg, p_nb0_reg, p_nb1_reg;
    logic signed [PW-1:0] p_den0_next, p_den1_next, p_na0_next, p_na1_next;
    logic signed [PW-1:0] p_nb0_next, p_nb1_next;

    // stage 3: denominator and numerators
    logic                 v3_reg;
    logic signed [W-1:0]  ax0_3_reg, ay0_3_reg;
    logic signed [DW-1:0] dxa_3_reg, dya_3_reg;
    logic signed [NW-1:0] den_3_reg, na_3_reg, nb_3_reg;
    logic signed [NW-1:0] den_3_next, na_3_next, nb_3_next;

    // stage 4: hit decision and magnitudes
    ssi_ctl_t             ctl_reg, ctl_next;
    logic signed [W-1:0]  start_x_reg, start_y_reg;
    logic [W-1:0]         dx_mag_reg, dy_mag_reg, dx_mag_next, dy_mag_next;
    logic [MW-1:0]        den_mag_reg, na_mag_reg, den_mag_next, na_mag_next;
    logic                 hit_pos, hit_neg;

    always_comb
    begin
        dxa_1_next = DW'(seg_a_end_x) - DW'(seg_a_start_x);
        dya_1_next = DW'(seg_a_end_y) - DW'(seg_a_start_y);
        dxb_1_next = DW'(seg_b_end_x) - DW'(seg_b_start_x);
        dyb_1_next = DW'(seg_b_end_y) - DW'(seg_b_start_y);
        ox_1_next  = DW'(seg_a_start_x) - DW'(seg_b_start_x);
        oy_1_next  = DW'(seg_a_start_y) - DW'(seg_b_start_y);

        p_den0_next = PW'(dyb_1_reg) * PW'(dxa_1_reg);
        p_den1_next = PW'(dxb_1_reg) * PW'(dya_1_reg);
        p_na0_next  = PW'(dxb_1_reg) * PW'(oy_1_reg);
        p_na1_next  = PW'(dyb_1_reg) * PW'(ox_1_reg);
        p_nb0_next  = PW'(dxa_1_reg) * PW'(oy_1_reg);
        p_nb1_next  = PW'(dya_1_reg) * PW'(ox_1_reg);

        den_3_next = NW'(p_den0_reg) - NW'(p_den1_reg);
        na_3_next  = NW'(p_na0_reg) - NW'(p_na1_reg);
        nb_3_next  = NW'(p_nb0_reg) - NW'(p_nb1_reg);

        // compare in the sign of the denominator instead of negating first
        hit_pos = (den_3_reg > 0) && (na_3_reg >= 0) && (na_3_reg <= den_3_reg)
                  && (nb_3_reg >= 0) && (nb_3_reg <= den_3_reg);
        hit_neg = (den_3_reg < 0) && (na_3_reg <= 0) && (na_3_reg >= den_3_reg)
                  && (nb_3_reg <= 0) && (nb_3_reg >= den_3_reg);

        ctl_next.valid = v3_reg;
        ctl_next.hit   = hit_pos || hit_neg;
        ctl_next.neg_x = dxa_3_reg < 0;
        ctl_next.neg_y = dya_3_reg < 0;

        dx_mag_next  = (dxa_3_reg < 0) ? W'(-dxa_3_reg) : W'(dxa_3_reg);
        dy_mag_next  = (dya_3_reg < 0) ? W'(-dya_3_reg) : W'(dya_3_reg);
        den_mag_next = (den_3_reg < 0) ? MW'(-den_3_reg) : MW'(den_3_reg);
        na_mag_next  = (den_3_reg < 0) ? MW'(-na_3_reg) : MW'(na_3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax0_1_reg <= seg_a_start_x;
        ay0_1_reg <= seg_a_start_y;
        dxa_1_reg <= dxa_1_next;
        dya_1_reg <= dya_1_next;
        dxb_1_reg <= dxb_1_next;
        dyb_1_reg <= dyb_1_next;
        ox_1_reg  <= ox_1_next;
        oy_1_reg  <= oy_1_next;

        ax0_2_reg  <= ax0_1_reg;
        ay0_2_reg  <= ay0_1_reg;
        dxa_2_reg  <= dxa_1_reg;
        dya_2_reg  <= dya_1_reg;
        p_den0_reg <= p_den0_next;
        p_den1_reg <= p_den1_next;
        p_na0_reg  <= p_na0_next;
        p_na1_reg  <= p_na1_next;
        p_nb0_reg  <= p_nb0_next;
        p_nb1_reg  <= p_nb1_next;

        ax0_3_reg <= ax0_2_reg;
        ay0_3_reg <= ay0_2_reg;
        dxa_3_reg <= dxa_2_reg;
        dya_3_reg <= dya_2_reg;
        den_3_reg <= den_3_next;
        na_3_reg  <= na_3_next;
        nb_3_reg  <= nb_3_next;

        start_x_reg <= ax0_3_reg;
        start_y_reg <= ay0_3_reg;
        dx_mag_reg  <= dx_mag_next;
        dy_mag_reg  <= dy_mag_next;
        den_mag_reg <= den_mag_next;
        na_mag_reg  <= na_mag_next;
    end

    assign ctl     = ctl_reg;
    assign start_x = start_x_reg;
    assign start_y = start_y_reg;
    assign dx_mag  = dx_mag_reg;
    assign dy_mag  = dy_mag_reg;
    assign den_mag = den_mag_reg;
    assign na_mag  = na_mag_reg;

    // a hit needs a live denominator and a parameter no larger than one
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && ctl_reg.hit |-> den_mag_reg != '0 && na_mag_reg <= den_mag_reg)
        else $error("hit flagged with parameter outside [0,1]");

endmodule

@@ rtl/ssi_scale.sv @@
// ============================================================================
// ssi_scale: numerator scaling
// Two stages: split partial products of the A numerator by the direction
// magnitudes, then sum them into the dividends for each axis.
// ============================================================================
module ssi_scale #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssi_pkg::ssi_ctl_t             ctl_in,
    input  logic signed [COORD_WIDTH-1:0] start_x_in,
    input  logic signed [COORD_WIDTH-1:0] start_y_in,
    input  logic [COORD_WIDTH-1:0]        dx_mag,
    input  logic [COORD_WIDTH-1:0]        dy_mag,
    input  logic [2*COORD_WIDTH:0]        den_in,
    input  logic [2*COORD_WIDTH:0]        na_mag,
    output ssi_pkg::ssi_ctl_t             ctl_out,
    output logic signed [COORD_WIDTH-1:0] start_x_out,
    output logic signed [COORD_WIDTH-1:0] start_y_out,
    output logic [2*COORD_WIDTH:0]        den_out,
    output logic [3*COORD_WIDTH:0]        num_x,
    output logic [3*COORD_WIDTH:0]        num_y
);
    import ssi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int MW   = 2 * W + 1;
    localparam int LW   = W + 1;        // low slice of the numerator
    localparam int HW   = MW - LW;      // high slice of the numerator
    localparam int PLW  = LW + W;
    localparam int PHW  = HW + W;
    localparam int NUMW = MW + W;

    ssi_ctl_t            ctl_1_reg, ctl_2_reg;
    logic signed [W-1:0] sx_1_reg, sy_1_reg, sx_2_reg, sy_2_reg;
    logic [MW-1:0]       den_1_reg, den_2_reg;
    logic [PLW-1:0]      plx_reg, ply_reg, plx_next, ply_next;
    logic [PHW-1:0]      phx_reg, phy_reg, phx_next, phy_next;
    logic [NUMW-1:0]     numx_reg, numy_reg, numx_next, numy_next;

    always_comb
    begin
        plx_next  = PLW'(na_mag[LW-1:0]) * PLW'(dx_mag);
        ply_next  = PLW'(na_mag[LW-1:0]) * PLW'(dy_mag);
        phx_next  = PHW'(na_mag[MW-1:LW]) * PHW'(dx_mag);
        phy_next  = PHW'(na_mag[MW-1:LW]) * PHW'(dy_mag);
        numx_next = NUMW'(plx_reg) + (NUMW'(phx_reg) << LW);
        numy_next = NUMW'(ply_reg) + (NUMW'(phy_reg) << LW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_1_reg <= '0;
            ctl_2_reg <= '0;
        end
        else
        begin
            ctl_1_reg <= ctl_in;
            ctl_2_reg <= ctl_1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_1_reg  <= start_x_in;
        sy_1_reg  <= start_y_in;
        den_1_reg <= den_in;
        plx_reg   <= plx_next;
        ply_reg   <= ply_next;
        phx_reg   <= phx_next;
        phy_reg   <= phy_next;
        sx_2_reg  <= sx_1_reg;
        sy_2_reg  <= sy_1_reg;
        den_2_reg <= den_1_reg;
        numx_reg  <= numx_next;
        numy_reg  <= numy_next;
    end

    assign ctl_out     = ctl_2_reg;
    assign start_x_out = sx_2_reg;
    assign start_y_out = sy_2_reg;
    assign den_out     = den_2_reg;
    assign num_x       = numx_reg;
    assign num_y       = numy_reg;

endmodule

@@ rtl/ssi_div_step.sv @@
// ============================================================================
// ssi_div_step: one restoring division step
// Resolves one quotient bit for both axes against the shared denominator.
// ============================================================================
module ssi_div_step #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF,
    parameter int SHIFT       = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssi_pkg::ssi_ctl_t             ctl_in,
    input  logic signed [COORD_WIDTH-1:0] start_x_in,
    input  logic signed [COORD_WIDTH-1:0] start_y_in,
    input  logic [2*COORD_WIDTH:0]        den_in,
    input  logic [3*COORD_WIDTH:0]        num_x_in,
    input  logic [3*COORD_WIDTH:0]        num_y_in,
    input  logic [COORD_WIDTH-1:0]        q_x_in,
    input  logic [COORD_WIDTH-1:0]        q_y_in,
    output ssi_pkg::ssi_ctl_t             ctl_out,
    output logic signed [COORD_WIDTH-1:0] start_x_out,
    output logic signed [COORD_WIDTH-1:0] start_y_out,
    output logic [2*COORD_WIDTH:0]        den_out,
    output logic [3*COORD_WIDTH:0]        num_x_out,
    output logic [3*COORD_WIDTH:0]        num_y_out,
    output logic [COORD_WIDTH-1:0]        q_x_out,
    output logic [COORD_WIDTH-1:0]        q_y_out
);
    import ssi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int MW   = 2 * W + 1;
    localparam int NUMW = MW + W;

    ssi_ctl_t            ctl_reg;
    logic signed [W-1:0] sx_reg, sy_reg;
    logic [MW-1:0]       den_reg;
    logic [NUMW-1:0]     numx_reg, numy_reg, numx_next, numy_next;
    logic [W-1:0]        qx_reg, qy_reg, qx_next, qy_next;
    logic [NUMW-1:0]     den_sh, den_lim;
    logic                ge_x, ge_y;

    always_comb
    begin
        den_sh    = NUMW'(den_in) << SHIFT;
        ge_x      = num_x_in >= den_sh;
        ge_y      = num_y_in >= den_sh;
        numx_next = ge_x ? (num_x_in - den_sh) : num_x_in;
        numy_next = ge_y ? (num_y_in - den_sh) : num_y_in;
        qx_next   = q_x_in;
        qy_next   = q_y_in;
        qx_next[SHIFT] = ge_x;
        qy_next[SHIFT] = ge_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg   <= start_x_in;
        sy_reg   <= start_y_in;
        den_reg  <= den_in;
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
    end

    assign ctl_out     = ctl_reg;
    assign start_x_out = sx_reg;
    assign start_y_out = sy_reg;
    assign den_out     = den_reg;
    assign num_x_out   = numx_reg;
    assign num_y_out   = numy_reg;
    assign q_x_out     = qx_reg;
    assign q_y_out     = qy_reg;

    assign den_lim = NUMW'(den_reg) << SHIFT;

    // after this step the partial remainder sits below the shifted divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && ctl_reg.hit |-> numx_reg < den_lim && numy_reg < den_lim)
        else $error("partial remainder not reduced below shifted divisor");

endmodule

@@ rtl/segment_segment_intersect.sv @@
// ============================================================================
// segment_segment_intersect: pipelined 2D segment intersection
// Exact fixed-point hit test of two segments and their crossing point.
// ============================================================================
//
// Usage:
//   Drive the eight Q12.4 endpoint coordinates and raise start for one cycle
//   per word. busy stays low, so a word is taken on every edge where start
//   is high: one pair per clock, back to back, with no gaps required.
//   Each word comes back as one result word: done is high for exactly one
//   cycle while hit, cross_x and cross_y carry it. Results leave in the
//   order the words entered.
// Pipeline: four geometry stages, two scaling stages, then the restoring
//   divider with one stage per coordinate bit, one quotient bit per
//   stage, and last the output register.
// Throughput: one word per cycle, fixed by the one-item-per-stage pipeline.
// Reset: rst_n clears every valid bit at once, dropping words in flight;
//   there is no other state. The receiver cannot stall, so done fires on
//   schedule and the caller must take the result word in that cycle.
//
module segment_segment_intersect #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y
);
    import ssi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int MW   = 2 * W + 1;
    localparam int NUMW = MW + W;
    localparam int SW   = W + 1;     // start plus or minus quotient

    // front end to scaler
    ssi_ctl_t            f_ctl;
    logic signed [W-1:0] f_sx, f_sy;
    logic [W-1:0]        f_dx, f_dy;
    logic [MW-1:0]       f_den, f_na;

    // divider chain: entry k feeds step k, entry W is the last step's output
    ssi_ctl_t            d_ctl [0:W];
    logic signed [W-1:0] d_sx  [0:W];
    logic signed [W-1:0] d_sy  [0:W];
    logic [MW-1:0]       d_den [0:W];
    logic [NUMW-1:0]     d_nx  [0:W];
    logic [NUMW-1:0]     d_ny  [0:W];
    logic [W-1:0]        d_qx  [0:W];
    logic [W-1:0]        d_qy  [0:W];

    // output register
    logic                done_reg, hit_reg, hit_next;
    logic signed [W-1:0] cross_x_reg, cross_y_reg, cross_x_next, cross_y_next;
    logic signed [SW-1:0] sum_x, sum_y;

    logic in_valid;

    // the pipeline never holds off a word
    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    ssi_front #(
        .COORD_WIDTH (W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .seg_a_start_x (seg_a_start_x),
        .seg_a_start_y (seg_a_start_y),
        .seg_a_end_x   (seg_a_end_x),
        .seg_a_end_y   (seg_a_end_y),
        .seg_b_start_x (seg_b_start_x),
        .seg_b_start_y (seg_b_start_y),
        .seg_b_end_x   (seg_b_end_x),
        .seg_b_end_y   (seg_b_end_y),
        .ctl           (f_ctl),
        .start_x       (f_sx),
        .start_y       (f_sy),
        .dx_mag        (f_dx),
        .dy_mag        (f_dy),
        .den_mag       (f_den),
        .na_mag        (f_na)
    );

    ssi_scale #(
        .COORD_WIDTH (W)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (f_ctl),
        .start_x_in  (f_sx),
        .start_y_in  (f_sy),
        .dx_mag      (f_dx),
        .dy_mag      (f_dy),
        .den_in      (f_den),
        .na_mag      (f_na),
        .ctl_out     (d_ctl[0]),
        .start_x_out (d_sx[0]),
        .start_y_out (d_sy[0]),
        .den_out     (d_den[0]),
        .num_x       (d_nx[0]),
        .num_y       (d_ny[0])
    );

    // quotient starts empty; each step fills one bit, most significant first
    assign d_qx[0] = '0;
    assign d_qy[0] = '0;

    for (genvar k = 0; k < W; k++)
    begin : g_div
        ssi_div_step #(
            .COORD_WIDTH (W),
            .SHIFT       (W - 1 - k)
        ) u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl_in      (d_ctl[k]),
            .start_x_in  (d_sx[k]),
            .start_y_in  (d_sy[k]),
            .den_in      (d_den[k]),
            .num_x_in    (d_nx[k]),
            .num_y_in    (d_ny[k]),
            .q_x_in      (d_qx[k]),
            .q_y_in      (d_qy[k]),
            .ctl_out     (d_ctl[k+1]),
            .start_x_out (d_sx[k+1]),
            .start_y_out (d_sy[k+1]),
            .den_out     (d_den[k+1]),
            .num_x_out   (d_nx[k+1]),
            .num_y_out   (d_ny[k+1]),
            .q_x_out     (d_qx[k+1]),
            .q_y_out     (d_qy[k+1])
        );
    end

    // step along A by the truncated quotient; the point stays on A, so the
    // low bits are exact and no saturation is needed
    always_comb
    begin
        sum_x = d_ctl[W].neg_x ? (SW'(d_sx[W]) - $signed({1'b0, d_qx[W]}))
                               : (SW'(d_sx[W]) + $signed({1'b0, d_qx[W]}));
        sum_y = d_ctl[W].neg_y ? (SW'(d_sy[W]) - $signed({1'b0, d_qy[W]}))
                               : (SW'(d_sy[W]) + $signed({1'b0, d_qy[W]}));
        hit_next     = d_ctl[W].valid && d_ctl[W].hit;
        cross_x_next = hit_next ? W'(sum_x) : '0;
        cross_y_next = hit_next ? W'(sum_y) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= d_ctl[W].valid;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cross_x_reg <= cross_x_next;
        cross_y_reg <= cross_y_next;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

    // a miss always reports the origin
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> cross_x == '0 && cross_y == '0)
        else $error("miss reported with nonzero crossing point");

    // hit is only raised with a result word
    a_hit_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit raised without done");

    // a word leaving the last divider step raises done in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        d_ctl[W].valid |=> done)
        else $error("finished word did not reach the output");

endmodule

@@ tb/tb_segment_segment_intersect.sv @@
// ============================================================================
// tb_segment_segment_intersect: self-checking bench for the segment
// intersection pipeline
// Words go in through the start/busy handshake with random gaps. Each one is
// checked against a behavioral intersection predictor built on 64-bit math,
// or against a hand-typed result for the obvious directed rows. Results are
// matched in order as done pulses arrive.
// ============================================================================
`timescale 1ns / 1ps

module tb_segment_segment_intersect;

    localparam int     CW        = ssi_pkg::COORD_WIDTH_DEF;
    localparam longint CMAX      = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN      = -(longint'(1) << (CW - 1));
    localparam int     LATENCY   = CW + 7;
    localparam int     N_RANDOM  = 750;
    localparam int     MAX_DRAIN = 2000;

    typedef logic signed [CW-1:0] coord_t;

    // One input word: both segments, start and end points.
    typedef struct packed {
        coord_t ax0, ay0, ax1, ay1;
        coord_t bx0, by0, bx1, by1;
    } seg_pair_t;

    // One result word.
    typedef struct packed {
        logic   hit;
        coord_t cx;
        coord_t cy;
    } crossing_t;

    // Directed row: the pair, plus a hand-typed result where it is obvious.
    typedef struct {
        seg_pair_t pair;
        bit        given;
        crossing_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    logic      hit;
    coord_t    cross_x;
    coord_t    cross_y;

    seg_pair_t word_in;
    logic      want_given;
    crossing_t want_row;

    crossing_t pending_crossings[$];
    dir_row_t  dir_rows[$];
    int        n_sent;
    int        n_taken;
    int        n_errors;
    bit        no_gaps;

    segment_segment_intersect #(
        .COORD_WIDTH(CW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seg_a_start_x(word_in.ax0),
        .seg_a_start_y(word_in.ay0),
        .seg_a_end_x  (word_in.ax1),
        .seg_a_end_y  (word_in.ay1),
        .seg_b_start_x(word_in.bx0),
        .seg_b_start_y(word_in.by0),
        .seg_b_end_x  (word_in.bx1),
        .seg_b_end_y  (word_in.by1),
        .done         (done),
        .hit          (hit),
        .cross_x      (cross_x),
        .cross_y      (cross_y)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor. Everything stays exact in 64 bits: the numerators reach
    // about 2*CW+1 bits and the scaled numerator about 3*CW+2 bits.
    // The denominator sign is folded into the numerators so that the range
    // tests become plain comparisons against a positive denominator.
    // ------------------------------------------------------------------------
    function automatic crossing_t intersect_segments(seg_pair_t p);
        longint    dxa, dya, dxb, dyb, ox, oy;
        longint    den, na, nb, qx, qy;
        crossing_t r;
        r   = '0;
        dxa = longint'(p.ax1) - longint'(p.ax0);
        dya = longint'(p.ay1) - longint'(p.ay0);
        dxb = longint'(p.bx1) - longint'(p.bx0);
        dyb = longint'(p.by1) - longint'(p.by0);
        ox  = longint'(p.ax0) - longint'(p.bx0);
        oy  = longint'(p.ay0) - longint'(p.by0);
        den = dyb * dxa - dxb * dya;
        na  = dxb * oy - dyb * ox;
        nb  = dxa * oy - dya * ox;
        // Parallel, collinear or zero-length: no crossing, point stays zero.
        if (den == 0)
            return r;
        if (den < 0)
        begin
            den = -den;
            na  = -na;
            nb  = -nb;
        end
        if (na >= 0 && na <= den && nb >= 0 && nb <= den)
        begin
            // Quotient of non-negative values truncates toward zero; apply
            // the direction sign afterward.
            qx   = (na * (dxa < 0 ? -dxa : dxa)) / den;
            qy   = (na * (dya < 0 ? -dya : dya)) / den;
            r.hit = 1'b1;
            r.cx  = coord_t'(dxa < 0 ? longint'(p.ax0) - qx : longint'(p.ax0) + qx);
            r.cy  = coord_t'(dya < 0 ? longint'(p.ay0) - qy : longint'(p.ay0) + qy);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic coord_t clamp_coord(longint v);
        if (v > CMAX)
            return coord_t'(CMAX);
        if (v < CMIN)
            return coord_t'(CMIN);
        return coord_t'(v);
    endfunction

    // Uniform coordinate in [-reach, reach]; full reach means raw bits.
    function automatic coord_t rand_coord(longint reach);
        if (reach >= CMAX)
            return coord_t'($urandom);
        return clamp_coord(longint'($urandom_range(0, int'(2 * reach))) - reach);
    endfunction

    // Random pair. Most pairs are built to cross or touch so the hit path
    // and the divider see real work; the rest are raw noise, parallel,
    // collinear and zero-length shapes.
    function automatic seg_pair_t make_random_pair();
        seg_pair_t p;
        longint    reach, px, py, vx, vy, dx, dy;
        int        kind, k1, k2, s;
        case ($urandom_range(0, 2))
            0:       reach = 64;
            1:       reach = 2048;
            default: reach = CMAX;
        endcase
        kind  = $urandom_range(0, 99);
        p.ax0 = rand_coord(reach);
        p.ay0 = rand_coord(reach);
        p.ax1 = rand_coord(reach);
        p.ay1 = rand_coord(reach);
        dx    = longint'(p.ax1) - longint'(p.ax0);
        dy    = longint'(p.ay1) - longint'(p.ay0);
        if (kind < 12)
        begin
            // raw noise on every bit
            p.bx0 = coord_t'($urandom);
            p.by0 = coord_t'($urandom);
            p.bx1 = coord_t'($urandom);
            p.by1 = coord_t'($urandom);
        end
        else if (kind < 18)
        begin
            // parallel copy of A, shifted
            vx    = longint'(rand_coord(reach));
            vy    = longint'(rand_coord(reach));
            p.bx0 = clamp_coord(longint'(p.ax0) + vx);
            p.by0 = clamp_coord(longint'(p.ay0) + vy);
            p.bx1 = clamp_coord(longint'(p.ax1) + vx);
            p.by1 = clamp_coord(longint'(p.ay1) + vy);
        end
        else if (kind < 23)
        begin
            // B on A's own line, partly overlapping or not
            k1    = $urandom_range(0, 16);
            k2    = $urandom_range(0, 16);
            p.bx0 = clamp_coord(longint'(p.ax0) + dx * (k1 - 4) / 8);
            p.by0 = clamp_coord(longint'(p.ay0) + dy * (k1 - 4) / 8);
            p.bx1 = clamp_coord(longint'(p.ax0) + dx * (k2 - 4) / 8);
            p.by1 = clamp_coord(longint'(p.ay0) + dy * (k2 - 4) / 8);
        end
        else if (kind < 27)
        begin
            // zero-length A, B random
            p.ax1 = p.ax0;
            p.ay1 = p.ay0;
            p.bx0 = rand_coord(reach);
            p.by0 = rand_coord(reach);
            p.bx1 = rand_coord(reach);
            p.by1 = rand_coord(reach);
        end
        else
        begin
            // B passes through a point on (or next to) A; s = 0 puts B's end
            // on that point, and k1 at 0 or 16 lands it on A's endpoints.
            k1    = $urandom_range(0, 16);
            s     = $urandom_range(0, 4);
            px    = longint'(p.ax0) + dx * k1 / 16;
            py    = longint'(p.ay0) + dy * k1 / 16;
            vx    = longint'(rand_coord(reach));
            vy    = longint'(rand_coord(reach));
            p.bx0 = clamp_coord(px - vx);
            p.by0 = clamp_coord(py - vy);
            p.bx1 = clamp_coord(px + vx * s / 2);
            p.by1 = clamp_coord(py + vy * s / 2);
            if ($urandom_range(0, 1))
            begin
                // swap B's ends to flip the denominator sign
                {p.bx0, p.bx1} = {p.bx1, p.bx0};
                {p.by0, p.by1} = {p.by1, p.by0};
            end
        end
        return p;
    endfunction

    task automatic add_row(input longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1,
                           input bit given = 1'b0, input bit h = 1'b0,
                           input longint cx = 0, input longint cy = 0);
        dir_row_t r;
        r.pair  = '{coord_t'(ax0), coord_t'(ay0), coord_t'(ax1), coord_t'(ay1),
                    coord_t'(bx0), coord_t'(by0), coord_t'(bx1), coord_t'(by1)};
        r.given = given;
        r.want  = '{h, coord_t'(cx), coord_t'(cy)};
        dir_rows.push_back(r);
    endtask

    // Present one word at a falling edge and hold it until the monitor has
    // seen it taken. Returns positioned at a falling edge, so the next word
    // can follow with no gap and no second assignment in the same step.
    task automatic drive_word(input seg_pair_t p, input bit given, input crossing_t w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        word_in    <= p;
        want_given <= given;
        want_row   <= w;
        n_sent++;
        do
            @(negedge clk);
        while (n_taken < n_sent);
        // Toggle between gappy and back-to-back stretches now and then.
        if ($urandom_range(0, 39) == 0)
            no_gaps = ~no_gaps;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: log accepted words, check result words in order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        crossing_t exp_word;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_crossings.push_back(want_given ? want_row
                                                       : intersect_segments(word_in));
                n_taken++;
            end
            if (done)
            begin
                if (pending_crossings.size() == 0)
                begin
                    $display("%0t: result with nothing expected: hit=%0b x=%0d y=%0d",
                             $time, hit, cross_x, cross_y);
                    n_errors++;
                end
                else
                begin
                    exp_word = pending_crossings.pop_front();
                    if (hit !== exp_word.hit)
                    begin
                        $display("%0t: hit mismatch: expected %0b, actual %0b",
                                 $time, exp_word.hit, hit);
                        n_errors++;
                    end
                    if (cross_x !== exp_word.cx)
                    begin
                        $display("%0t: cross_x mismatch: expected %0d, actual %0d",
                                 $time, exp_word.cx, cross_x);
                        n_errors++;
                    end
                    if (cross_y !== exp_word.cy)
                    begin
                        $display("%0t: cross_y mismatch: expected %0d, actual %0d",
                                 $time, exp_word.cy, cross_y);
                        n_errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int drain;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        word_in    = '0;
        want_given = 1'b0;
        want_row   = '0;
        n_sent     = 0;
        n_taken    = 0;
        n_errors   = 0;
        no_gaps    = 1'b0;

        // Directed rows. Obvious outcomes are typed in; the rest go
        // through the predictor.
        // all zero: zero-length segments, no hit
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // plain cross at the origin
        add_row(-16, 0, 16, 0, 0, -16, 0, 16, 1, 1, 0, 0);
        // same cross with roles swapped: negative denominator
        add_row(0, -16, 0, 16, -16, 0, 16, 0, 1, 1, 0, 0);
        // B touches A's end point: A parameter exactly one
        add_row(0, 0, 32, 0, 32, -16, 32, 16, 1, 1, 32, 0);
        // B touches A's start point: A parameter exactly zero
        add_row(0, 0, 32, 0, 0, -16, 0, 16, 1, 1, 0, 0);
        // A's end lands on B's start: both parameters at an endpoint
        add_row(0, 0, 32, 32, 32, 32, 64, 0, 1, 1, 32, 32);
        // parallel, one unit apart
        add_row(0, 0, 32, 0, 0, 16, 32, 16, 1, 0, 0, 0);
        // collinear and overlapping
        add_row(0, 0, 32, 0, 16, 0, 48, 0, 1, 0, 0, 0);
        // zero-length A lying on B
        add_row(5, 5, 5, 5, 0, 0, 10, 10, 1, 0, 0, 0);
        // lines cross beyond A's end
        add_row(0, 0, 16, 0, 32, -16, 32, 16, 1, 0, 0, 0);
        // lines cross beyond B's end, one LSB short
        add_row(0, 0, 32, 0, 16, 16, 16, 1, 1, 0, 0, 0);
        // all coordinates at the maximum, then at the minimum
        add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 0, 0, 0);
        add_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1, 0, 0, 0);
        // full-range diagonals crossing near the middle
        add_row(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        // full-range axes
        add_row(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
        add_row(CMAX, 0, CMIN, 0, 0, CMAX, 0, CMIN);
        // fractional crossing, positive and negative directions (truncation)
        add_row(0, 0, 3, 1, 0, 1, 3, 0);
        add_row(3, 1, 0, 0, 0, 1, 3, 0);
        add_row(0, 0, -7, -3, -3, 0, -3, -5);
        // alternating bit patterns
        add_row(16'sh5555, -16'sh5556, -16'sh5556, 16'sh5555,
                -16'sh5556, -16'sh5556, 16'sh5555, 16'sh5555);
        add_row(-1, 1, 1, -1, -1, -1, 1, 1);
        // near-parallel long segments, extreme corners
        add_row(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX, CMAX - 1);
        add_row(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN);

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            drive_word(dir_rows[i].pair, dir_rows[i].given, dir_rows[i].want);

        for (int i = 0; i < N_RANDOM; i++)
            drive_word(make_random_pair(), 1'b0, '0);

        start <= 1'b0;

        // Drain: wait for every expected word, bounded.
        drain = 0;
        while (pending_crossings.size() != 0 && drain < MAX_DRAIN)
        begin
            @(posedge clk);
            drain++;
        end
        // Then keep watching for any stray done pulse.
        repeat (2 * LATENCY) @(posedge clk);

        if (n_errors == 0 && pending_crossings.size() == 0)
            $display("tb_segment_segment_intersect OK");
        else
            $display("tb_segment_segment_intersect NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (under 50 us).
    initial
    begin
        #2000000;
        $display("tb_segment_segment_intersect NOT OK");
        $finish;
    end

endmodule
